[rtl/core/cc20_pkg.sv]
// Shared types, constants and a helper function for the ChaCha20 stream XOR block.
package cc20_pkg;

  // Beat carried on the input channel.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } cc20_in_t;

  // Beat carried on the output channel.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } cc20_out_t;

  // Key and nonce as held in the configuration registers.
  typedef struct packed {
    logic [63:0] key_word_a;
    logic [63:0] key_word_b;
    logic [63:0] key_word_c;
    logic [63:0] key_word_d;
    logic [63:0] nonce_low;
    logic [31:0] nonce_high;
  } cc20_key_t;

  // Keystream word writes and completion from the block generator.
  typedef struct packed {
    logic        wr_en;
    logic [3:0]  wr_addr;
    logic [31:0] wr_data;
    logic        done;
  } cc20_core_out_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_KEY_A      = 3'd0;
  localparam logic [2:0] REG_KEY_B      = 3'd1;
  localparam logic [2:0] REG_KEY_C      = 3'd2;
  localparam logic [2:0] REG_KEY_D      = 3'd3;
  localparam logic [2:0] REG_NONCE_LOW  = 3'd4;
  localparam logic [2:0] REG_NONCE_HIGH = 3'd5;

  // The "expand 32-byte k" constants.
  localparam logic [31:0] SIGMA_0 = 32'h61707865;
  localparam logic [31:0] SIGMA_1 = 32'h3320646e;
  localparam logic [31:0] SIGMA_2 = 32'h79622d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b206574;

  localparam int DOUBLE_ROUNDS = 10;
  localparam int BLOCK_BYTES   = 64;

  // Rotates a row of four words so that word k lands in word position 0.
  function automatic logic [127:0] cc20_row_rol(input logic [127:0] row, input logic [1:0] k);
    logic [255:0] dbl;
    dbl = {row, row} >> {k, 5'd0};
    return dbl[127:0];
  endfunction

endpackage

[rtl/core/cc20_core.sv]
// ChaCha20 block generator built around one shared add, xor and rotate unit.
module cc20_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  cc20_pkg::cc20_key_t      key,
  input  logic [31:0]              counter,
  output cc20_pkg::cc20_core_out_t status
);
  import cc20_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ROUND = 2'd1;
  localparam logic [1:0] S_ADD   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] step;
  logic [2:0] qr;
  logic [3:0] rnd;
  logic [3:0] add_cnt;

  // Working state held as four rows; word 0 of each row is the unit's tap.
  logic [127:0] a_row, b_row, c_row, d_row;
  logic [511:0] init_w;

  logic         in_add, odd;
  logic [31:0]  a0, b0, c0, d0;
  logic [31:0]  p, q, sum, mix, rot;
  logic [127:0] a_upd, b_upd, c_upd, d_upd;
  logic [1:0]   ka, kb, kc, kd;
  logic         last_step;

  always_comb begin
    in_add = (state == S_ADD);
    odd    = step[0];
    a0     = a_row[31:0];
    b0     = b_row[31:0];
    c0     = c_row[31:0];
    d0     = d_row[31:0];
    p      = (!in_add && odd) ? c0 : a0;
    q      = in_add ? init_w[31:0] : (odd ? d0 : b0);
    sum    = p + q;
    mix    = (odd ? b0 : d0) ^ sum;
    case (step)
      2'd0:    rot = {mix[15:0], mix[31:16]};
      2'd1:    rot = {mix[19:0], mix[31:20]};
      2'd2:    rot = {mix[23:0], mix[31:24]};
      default: rot = {mix[24:0], mix[31:25]};
    endcase

    a_upd = odd ? a_row : {a_row[127:32], sum};
    d_upd = odd ? d_row : {d_row[127:32], rot};
    c_upd = odd ? {c_row[127:32], sum} : c_row;
    b_upd = odd ? {b_row[127:32], rot} : b_row;

    // After each quarter round the rows move left one word. At the end of the
    // column pass the rows also take the diagonal skew, and at the end of the
    // diagonal pass the skew is taken back out.
    last_step = (step == 2'd3);
    ka = 2'd0;
    kb = 2'd0;
    kc = 2'd0;
    kd = 2'd0;
    if (last_step) begin
      case (qr)
        3'd3: begin
          ka = 2'd1; kb = 2'd2; kc = 2'd3; kd = 2'd0;
        end
        3'd7: begin
          ka = 2'd1; kb = 2'd0; kc = 2'd3; kd = 2'd2;
        end
        default: begin
          ka = 2'd1; kb = 2'd1; kc = 2'd1; kd = 2'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      step    <= 2'd0;
      qr      <= 3'd0;
      rnd     <= 4'd0;
      add_cnt <= 4'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_ROUND;
            step  <= 2'd0;
            qr    <= 3'd0;
            rnd   <= 4'd0;
          end
        end
        S_ROUND: begin
          step <= step + 2'd1;
          if (last_step) begin
            qr <= qr + 3'd1;
            if (qr == 3'd7) begin
              rnd <= rnd + 4'd1;
              if (rnd == 4'(DOUBLE_ROUNDS - 1)) begin
                state   <= S_ADD;
                add_cnt <= 4'd0;
              end
            end
          end
        end
        S_ADD: begin
          add_cnt <= add_cnt + 4'd1;
          if (add_cnt == 4'd15) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      a_row  <= {SIGMA_3, SIGMA_2, SIGMA_1, SIGMA_0};
      b_row  <= {key.key_word_b, key.key_word_a};
      c_row  <= {key.key_word_d, key.key_word_c};
      d_row  <= {key.nonce_high, key.nonce_low, counter};
      init_w <= {key.nonce_high, key.nonce_low, counter,
                 key.key_word_d, key.key_word_c,
                 key.key_word_b, key.key_word_a,
                 SIGMA_3, SIGMA_2, SIGMA_1, SIGMA_0};
    end else if (state == S_ROUND) begin
      a_row <= cc20_row_rol(a_upd, ka);
      b_row <= cc20_row_rol(b_upd, kb);
      c_row <= cc20_row_rol(c_upd, kc);
      d_row <= cc20_row_rol(d_upd, kd);
    end else if (in_add) begin
      // Feed-forward: both word lines shift down so word 0 is the next pair.
      {d_row, c_row, b_row, a_row} <= {32'd0, d_row, c_row, b_row, a_row[127:32]};
      init_w <= {32'd0, init_w[511:32]};
    end
  end

  assign status.wr_en   = in_add;
  assign status.wr_addr = add_cnt;
  assign status.wr_data = sum;
  assign status.done    = (state == S_DONE);

endmodule

[rtl/core/chacha20_stream_xor.sv]
// Top level of the ChaCha20 stream XOR block: handshakes, registers, keystream store.
// An accepted beat waits in the holding register while the sequencer reads the keystream
// store and emits the result once the output register is free; only then is the next
// beat taken. A byte at a block boundary waits for the block generator as well:
// 320 quarter-round steps on the shared add-xor-rotate unit plus 16 feed-forward adds.
// Reset (rst, synchronous, active high) clears the key and nonce registers, the byte
// position, the block counter and all handshake state; the keystream store is not cleared.
module chacha20_stream_xor (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  cc20_pkg::cc20_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cc20_pkg::cc20_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import cc20_pkg::*;

  // Item sequencer codes.
  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_GEN  = 2'd1;
  localparam logic [1:0] T_READ = 2'd2;
  localparam logic [1:0] T_EMIT = 2'd3;

  logic [1:0]     state;
  logic           pending;
  cc20_in_t       hold;
  cc20_key_t      key;
  logic [5:0]     pos;
  logic [31:0]    ctr;
  logic           core_start;
  cc20_core_out_t core_status;
  logic [31:0]    ks_mem [16];
  logic [31:0]    rd_word;
  logic [31:0]    ks_shift;
  logic           out_free;
  logic           emit;

  // The configuration port never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_A:      key.key_word_a <= cfg_data;
        REG_KEY_B:      key.key_word_b <= cfg_data;
        REG_KEY_C:      key.key_word_c <= cfg_data;
        REG_KEY_D:      key.key_word_d <= cfg_data;
        REG_NONCE_LOW:  key.nonce_low  <= cfg_data;
        REG_NONCE_HIGH: key.nonce_high <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  // The input beat is parked in a holding register, so stall is simply
  // "a byte is still being worked on".
  assign in_stall = pending;

  // A new keystream block is made whenever the byte to be served sits at
  // position zero of a block.
  assign core_start = (state == T_IDLE) && pending && (pos == 6'd0);

  cc20_core u_core (
    .clk     (clk),
    .rst     (rst),
    .start   (core_start),
    .key     (key),
    .counter (ctr),
    .status  (core_status)
  );

  // Keystream store, one 32-bit word per entry, read at the word holding the
  // current byte position.
  always_ff @(posedge clk) begin
    if (core_status.wr_en) begin
      ks_mem[core_status.wr_addr] <= core_status.wr_data;
    end
    rd_word <= ks_mem[pos[5:2]];
  end

  // Words are serialized little-endian, so the low position bits pick the byte.
  assign ks_shift = rd_word >> {pos[1:0], 3'd0};

  // The output register can take a result when it is empty or being drained.
  assign out_free = !out_valid || !out_stall;
  assign emit     = (state == T_EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= T_IDLE;
      pending <= 1'b0;
      pos     <= 6'd0;
      ctr     <= 32'd0;
    end else begin
      if (in_valid && !in_stall) begin
        pending <= 1'b1;
      end
      case (state)
        T_IDLE: begin
          if (pending) begin
            state <= (pos == 6'd0) ? T_GEN : T_READ;
          end
        end
        T_GEN: begin
          if (core_status.done) begin
            state <= T_READ;
          end
        end
        T_READ: begin
          state <= T_EMIT;
        end
        T_EMIT: begin
          if (out_free) begin
            state   <= T_IDLE;
            pending <= 1'b0;
            // A last byte ends the buffer; otherwise step on and bump the
            // counter when the position wraps past the end of the block.
            if (hold.last_byte) begin
              pos <= 6'd0;
              ctr <= 32'd0;
            end else begin
              pos <= pos + 6'd1;
              if (pos == 6'(BLOCK_BYTES - 1)) begin
                ctr <= ctr + 32'd1;
              end
            end
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.out_byte <= hold.data_byte ^ ks_shift[7:0];
      out_data.out_last <= hold.last_byte;
    end
  end

endmodule

[tb/sv/chacha20_stream_xor_test.sv]
// Self-checking testbench for the ChaCha20 stream XOR block with its own keystream model.
module chacha20_stream_xor_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cc20_pkg::*;

  // Register indexes beyond the six real ones; writes to them must be dropped.
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  // The quiet time at the end covers more than one keystream block, and a register
  // write only follows once every owed beat has come back.
  localparam int SETTLE_CYCLES  = 10;
  localparam int END_CYCLES     = 400;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int RANDOM_BEATS   = 1100;

  // What to load into the key and nonce registers after a directed row.
  typedef enum logic [1:0] {CFG_KEEP, CFG_ALL_ZERO, CFG_ALL_ONES, CFG_MIXED} cfg_plan_t;

  // One row of the directed part. Where "typed" is set, the expected output byte is
  // written in the row; otherwise the keystream model supplies it.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    logic [7:0] want;
    cfg_plan_t  then_cfg;
  } dir_row_t;

  localparam int DIR_ROWS = 19;

  // After reset the key and nonce are zero and the counter starts at 0, so the first
  // keystream bytes are the well-known all-zero ChaCha20 block: 76 b8 e0 ad a0 f1 ...
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, 8'h76, CFG_KEEP},
    '{8'h00, 1'b0, 1'b1, 8'hb8, CFG_KEEP},
    '{8'h00, 1'b0, 1'b1, 8'he0, CFG_KEEP},
    '{8'h00, 1'b0, 1'b1, 8'had, CFG_KEEP},
    '{8'hff, 1'b0, 1'b1, 8'h5f, CFG_KEEP},
    '{8'h55, 1'b1, 1'b1, 8'ha4, CFG_KEEP},
    // A last byte sends the position and counter back to zero.
    '{8'h00, 1'b0, 1'b1, 8'h76, CFG_KEEP},
    '{8'h0f, 1'b1, 1'b1, 8'hb7, CFG_ALL_ONES},
    '{8'hff, 1'b0, 1'b0, 8'h00, CFG_KEEP},
    '{8'h80, 1'b0, 1'b0, 8'h00, CFG_KEEP},
    '{8'h01, 1'b1, 1'b0, 8'h00, CFG_ALL_ZERO},
    '{8'h00, 1'b0, 1'b1, 8'h76, CFG_KEEP},
    // Key change in the middle of a buffer: the block already held is kept.
    '{8'h00, 1'b0, 1'b1, 8'hb8, CFG_MIXED},
    '{8'h00, 1'b0, 1'b1, 8'he0, CFG_KEEP},
    '{8'h00, 1'b1, 1'b1, 8'had, CFG_KEEP},
    '{8'h3c, 1'b1, 1'b0, 8'h00, CFG_MIXED},
    '{8'hff, 1'b1, 1'b0, 8'h00, CFG_KEEP},
    '{8'h00, 1'b0, 1'b0, 8'h00, CFG_KEEP},
    '{8'haa, 1'b1, 1'b0, 8'h00, CFG_KEEP}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  cc20_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  cc20_out_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  chacha20_stream_xor dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Keystream model state: its own copy of the key registers, the held block,
  // the byte position inside it and the 32-bit block counter.
  logic [63:0] key_words [4];
  logic [63:0] nonce_lo;
  logic [31:0] nonce_hi;
  logic [7:0]  keystream [64];
  logic [5:0]  stream_pos;
  logic [31:0] block_ctr;
  logic [31:0] block_init [16];
  logic [31:0] round_w [16];

  // Output beats still owed by the block, oldest first.
  cc20_out_t   pending_bytes [$];
  int unsigned mismatches = 0;

  // Pacing shared by both sides. In burst mode neither side inserts random idle cycles.
  bit          burst_mode = 1'b0;
  bit          rx_hold_req = 1'b0;
  int unsigned rx_hold_left = 0;
  int unsigned rx_wait_left = 0;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void quarter_round(input int a, input int b, input int c, input int d);
    round_w[a] = round_w[a] + round_w[b];
    round_w[d] = rotl32(round_w[d] ^ round_w[a], 16);
    round_w[c] = round_w[c] + round_w[d];
    round_w[b] = rotl32(round_w[b] ^ round_w[c], 12);
    round_w[a] = round_w[a] + round_w[b];
    round_w[d] = rotl32(round_w[d] ^ round_w[a], 8);
    round_w[c] = round_w[c] + round_w[d];
    round_w[b] = rotl32(round_w[b] ^ round_w[c], 7);
  endfunction

  // Builds the 64-byte keystream block for the current key, nonce and counter.
  function automatic void make_keystream_block();
    logic [31:0] sum;
    block_init[0]  = SIGMA_0;
    block_init[1]  = SIGMA_1;
    block_init[2]  = SIGMA_2;
    block_init[3]  = SIGMA_3;
    for (int k = 0; k < 4; k++) begin
      block_init[4 + 2 * k] = key_words[k][31:0];
      block_init[5 + 2 * k] = key_words[k][63:32];
    end
    block_init[12] = block_ctr;
    block_init[13] = nonce_lo[31:0];
    block_init[14] = nonce_lo[63:32];
    block_init[15] = nonce_hi;
    for (int i = 0; i < 16; i++) round_w[i] = block_init[i];
    for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
      quarter_round(0, 4, 8, 12);
      quarter_round(1, 5, 9, 13);
      quarter_round(2, 6, 10, 14);
      quarter_round(3, 7, 11, 15);
      quarter_round(0, 5, 10, 15);
      quarter_round(1, 6, 11, 12);
      quarter_round(2, 7, 8, 13);
      quarter_round(3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) begin
      sum = round_w[i] + block_init[i];
      for (int b = 0; b < 4; b++) keystream[4 * i + b] = sum[8 * b +: 8];
    end
  endfunction

  // Works out the output beat for one input beat and advances position and counter.
  function automatic cc20_out_t xor_keystream(input cc20_in_t beat);
    cc20_out_t res;
    if (stream_pos == 6'd0) make_keystream_block();
    res.out_byte = beat.data_byte ^ keystream[stream_pos];
    res.out_last = beat.last_byte;
    if (beat.last_byte) begin
      stream_pos = 6'd0;
      block_ctr  = 32'd0;
    end else begin
      stream_pos = stream_pos + 6'd1;
      if (stream_pos == 6'd0) block_ctr = block_ctr + 32'd1;
    end
    return res;
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [63:0] value);
    case (idx)
      REG_KEY_A:      key_words[0] = value;
      REG_KEY_B:      key_words[1] = value;
      REG_KEY_C:      key_words[2] = value;
      REG_KEY_D:      key_words[3] = value;
      REG_NONCE_LOW:  nonce_lo = value;
      REG_NONCE_HIGH: nonce_hi = value[31:0];
      default: ;
    endcase
  endfunction

  // Offers one input beat after a random number of idle cycles (none in burst mode),
  // waits until it is taken and queues the output beat it must produce.
  task automatic send_beat(input cc20_in_t beat, input logic typed, input logic [7:0] want);
    int unsigned gap;
    cc20_out_t   owed;
    gap = burst_mode ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    owed = xor_keystream(beat);
    if (typed) owed.out_byte = want;
    pending_bytes.push_back(owed);
  endtask

  // Stops offering input and waits until every owed output beat has been seen,
  // then lets the clock run on so the block is fully at rest.
  task automatic drain_outputs();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, value);
  endtask

  // Loads all six registers according to the plan, then pokes the two unused
  // indexes with random data, which the block has to ignore.
  task automatic load_settings(input cfg_plan_t plan);
    logic [2:0]  reg_order [6];
    logic [63:0] value;
    reg_order = '{REG_KEY_A, REG_KEY_B, REG_KEY_C, REG_KEY_D, REG_NONCE_LOW, REG_NONCE_HIGH};
    drain_outputs();
    for (int i = 0; i < 6; i++) begin
      case (plan)
        CFG_ALL_ZERO: value = '0;
        CFG_ALL_ONES: value = '1;
        default:      value = {$urandom, $urandom};
      endcase
      write_reg(reg_order[i], value);
    end
    write_reg(REG_SPARE_6, {$urandom, $urandom});
    write_reg(REG_SPARE_7, {$urandom, $urandom});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver pacing. After each output beat it stalls for a drawn number of cycles;
  // on request it also holds off for a long stretch so the block backs up.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req  = 1'b0;
        rx_hold_left = RX_HOLD_CYCLES;
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        out_stall <= 1'b1;
      end else if (rx_wait_left != 0) begin
        rx_wait_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Output checker: each beat taken is compared field by field with the oldest
  // owed beat. Only the first ten problems are printed.
  always @(posedge clk) begin
    cc20_out_t owed;
    if (!rst && out_valid && !out_stall) begin
      rx_wait_left = burst_mode ? 0 : $urandom_range(0, 6);
      if (pending_bytes.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected output beat: byte %h last %b", out_data.out_byte,
                   out_data.out_last);
        mismatches++;
      end else begin
        owed = pending_bytes.pop_front();
        if (out_data.out_byte !== owed.out_byte || out_data.out_last !== owed.out_last) begin
          if (mismatches < 10)
            $display("output mismatch: expected byte %h last %b, got byte %h last %b",
                     owed.out_byte, owed.out_last, out_data.out_byte, out_data.out_last);
          mismatches++;
        end
      end
    end
  end

  // Stimulus: reset, the directed table, then random buffers of random length.
  initial begin
    cc20_in_t    beat;
    int unsigned sent;
    int unsigned buffers;
    int unsigned len;
    int unsigned split_at;
    int unsigned pick;

    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_KEY_A;
    cfg_data  = '0;
    for (int k = 0; k < 4; k++) key_words[k] = '0;
    nonce_lo   = '0;
    nonce_hi   = '0;
    for (int i = 0; i < 64; i++) keystream[i] = '0;
    stream_pos = '0;
    block_ctr  = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      beat.data_byte = dir_rows[r].data;
      beat.last_byte = dir_rows[r].last;
      send_beat(beat, dir_rows[r].typed, dir_rows[r].want);
      if (dir_rows[r].then_cfg != CFG_KEEP) load_settings(dir_rows[r].then_cfg);
    end

    // Random part. Most buffers are short so that many of them start a fresh block;
    // some run past one or two 64-byte boundaries to exercise the counter.
    sent    = 0;
    buffers = 0;
    while (sent < RANDOM_BEATS) begin
      if (buffers != 0 && $urandom_range(0, 5) == 0)
        load_settings(cfg_plan_t'($urandom_range(1, 3)));

      pick = $urandom_range(0, 9);
      if (pick <= 5)      len = $urandom_range(1, 16);
      else if (pick <= 7) len = $urandom_range(17, 70);
      else if (pick == 8) len = $urandom_range(60, 140);
      else                len = 1;
      if (buffers == 0) len = 130;
      burst_mode = ($urandom_range(0, 4) == 0);

      // Once, the receiver stops for a long stretch while a long buffer is pushed in
      // at full speed, so the block fills and stalls its input.
      if (buffers == 2) begin
        len         = 120;
        burst_mode  = 1'b1;
        rx_hold_req = 1'b1;
      end

      // Now and then the key changes part way through a buffer.
      split_at = 0;
      if (len > 2 && $urandom_range(0, 7) == 0) split_at = $urandom_range(1, len - 1);

      for (int unsigned k = 0; k < len; k++) begin
        if (split_at != 0 && k == split_at) load_settings(CFG_MIXED);
        beat.data_byte = 8'($urandom_range(0, 255));
        beat.last_byte = (k == len - 1);
        send_beat(beat, 1'b0, 8'h00);
        sent++;
      end
      buffers++;
    end

    burst_mode = 1'b0;
    drain_outputs();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run: every beat starting a new block.
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule

[sim.f]
rtl/core/cc20_pkg.sv
rtl/core/cc20_core.sv
rtl/core/chacha20_stream_xor.sv
tb/sv/chacha20_stream_xor_test.sv
